FILE: src/rbc_pkg.sv
// Shared types and codes for the reversible blower controller.
// No dependencies; every module of the block imports this package.
package rbc_pkg;

  // Width of each configuration register.
  localparam int unsigned CfgWidth = 16;

  // Number of blower channels handled by the block.
  localparam int unsigned NumCh = 2;

  typedef enum logic [1:0] {
    MODE_STOP  = 2'd0,
    MODE_FWD   = 2'd1,
    MODE_REV   = 2'd2,
    MODE_PAUSE = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    EV_NONE = 2'd0,
    EV_FWD  = 2'd1,
    EV_REV  = 2'd2,
    EV_STOP = 2'd3
  } event_e;

  typedef enum logic [2:0] {
    ST_NONE      = 3'd0,
    ST_FWD_OK    = 3'd1,
    ST_REV_OK    = 3'd2,
    ST_STOPPED   = 3'd3,
    ST_FWD_FAULT = 3'd4,
    ST_REV_FAULT = 3'd5,
    ST_SWITCHING = 3'd6
  } status_e;

  typedef enum logic {
    CMD_TICK   = 1'b0,
    CMD_RESYNC = 1'b1
  } command_e;

  // Configuration register indexes; register i sits at byte address 4 * i.
  typedef enum logic {
    REG_CHECK_PERIOD = 1'b0,
    REG_PAUSE_TICKS  = 1'b1
  } reg_idx_e;

  // Two-bit drive and feedback pair of one channel.
  localparam logic [1:0] PairFwd = 2'b01;
  localparam logic [1:0] PairRev = 2'b10;
  localparam logic [1:0] PairOff = 2'b00;
  localparam logic [1:0] PairBoth = 2'b11;

  typedef struct packed {
    logic       command;
    logic [1:0] event_ch0;
    logic [1:0] event_ch1;
    logic [3:0] feedback;
  } in_item_t;

  typedef struct packed {
    logic [3:0] drive;
    logic [2:0] status_ch0;
    logic [2:0] status_ch1;
    logic [1:0] mode_ch0;
    logic [1:0] mode_ch1;
  } out_item_t;

  // Post-update view of one channel, handed from a lane to the merge stage.
  typedef struct packed {
    logic [1:0] drive;
    status_e    status;
    mode_e      mode;
  } lane_res_t;

endpackage

FILE: src/rbc_lane.sv
// One blower channel: mode machine, monitor and pause counters, status.
// Depends on rbc_pkg.
module rbc_lane import rbc_pkg::*; #(
  parameter int unsigned COUNT_WIDTH = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                accept_i,
  input  logic                command_i,
  input  logic [1:0]          event_i,
  input  logic [1:0]          feedback_i,
  input  logic [CfgWidth-1:0] check_period_i,
  input  logic [CfgWidth-1:0] pause_ticks_i,
  output lane_res_t           res_o
);

  localparam int unsigned CmpWidth = (COUNT_WIDTH > CfgWidth) ? COUNT_WIDTH : CfgWidth;

  mode_e                  mode_q, mode_d;
  status_e                status_q, status_d;
  logic                   last_dir_q, last_dir_d;
  logic [COUNT_WIDTH-1:0] mon_q, mon_d;
  logic [COUNT_WIDTH-1:0] pause_q, pause_d;
  logic [1:0]             last_fb_q, last_fb_d;
  logic [1:0]             drive_q, drive_d;

  logic                   changed;
  logic [COUNT_WIDTH-1:0] mon_old;
  logic [COUNT_WIDTH-1:0] pause_inc;
  logic [CmpWidth-1:0]    mon_old_x, period_x, pause_x, limit_x;

  assign changed   = (feedback_i != last_fb_q);
  assign pause_inc = pause_q + COUNT_WIDTH'(1);
  assign period_x  = CmpWidth'(check_period_i);
  assign pause_x   = CmpWidth'(pause_inc);
  assign limit_x   = CmpWidth'(pause_ticks_i);

  always_comb begin
    mode_d     = mode_q;
    status_d   = status_q;
    last_dir_d = last_dir_q;
    mon_d      = mon_q;
    pause_d    = pause_q;
    last_fb_d  = last_fb_q;
    drive_d    = drive_q;
    mon_old    = mon_q;
    mon_old_x  = CmpWidth'(mon_q);

    if (command_i == CMD_RESYNC) begin
      // A channel whose feedback shows both directions keeps its mode.
      case (feedback_i)
        PairFwd: begin
          mode_d   = MODE_FWD;
          status_d = ST_FWD_OK;
        end
        PairRev: begin
          mode_d   = MODE_REV;
          status_d = ST_REV_OK;
        end
        PairOff: begin
          mode_d   = MODE_STOP;
          status_d = ST_STOPPED;
        end
        default: ;
      endcase
    end else begin
      last_fb_d = feedback_i;
      unique case (mode_q)
        MODE_REV: begin
          // Leaving reverse for a pause keeps the monitor count running.
          if (event_i == EV_FWD) begin
            drive_d    = PairOff;
            mode_d     = MODE_PAUSE;
            pause_d    = '0;
            last_dir_d = 1'b1;
          end
          if (event_i == EV_STOP) begin
            drive_d = PairOff;
            mode_d  = MODE_STOP;
            mon_d   = '0;
          end
          if (changed) mon_d = '0;
          mon_old   = mon_d;
          mon_old_x = CmpWidth'(mon_old);
          mon_d     = mon_old + COUNT_WIDTH'(1);
          if (mon_old_x == period_x) begin
            status_d = feedback_i[1] ? ST_REV_OK : ST_REV_FAULT;
            mon_d    = '0;
          end
        end
        MODE_FWD: begin
          if (event_i == EV_REV) begin
            drive_d    = PairOff;
            mode_d     = MODE_PAUSE;
            pause_d    = '0;
            last_dir_d = 1'b0;
            mon_d      = '0;
          end
          if (event_i == EV_STOP) begin
            drive_d = PairOff;
            mode_d  = MODE_STOP;
            mon_d   = '0;
          end
          if (changed) mon_d = '0;
          mon_old   = mon_d;
          mon_old_x = CmpWidth'(mon_old);
          mon_d     = mon_old + COUNT_WIDTH'(1);
          if (mon_old_x == period_x) begin
            status_d = feedback_i[0] ? ST_FWD_OK : ST_FWD_FAULT;
            mon_d    = '0;
          end
        end
        MODE_STOP: begin
          // Starting ORs the direction into the drive pair; it does not clear it.
          if (event_i == EV_FWD) begin
            drive_d = drive_q | PairFwd;
            mode_d  = MODE_FWD;
            mon_d   = '0;
          end else if (event_i == EV_REV) begin
            drive_d = drive_q | PairRev;
            mode_d  = MODE_REV;
            mon_d   = '0;
          end
          if (changed) mon_d = '0;
          mon_old   = mon_d;
          mon_old_x = CmpWidth'(mon_old);
          mon_d     = mon_old + COUNT_WIDTH'(1);
          if (mon_old_x >= period_x) begin
            if (feedback_i == PairOff) begin
              status_d = ST_STOPPED;
            end else if (feedback_i[1]) begin
              status_d = ST_REV_FAULT;
            end else begin
              status_d = ST_FWD_FAULT;
            end
            mon_d = '0;
          end
        end
        MODE_PAUSE: begin
          status_d = ST_SWITCHING;
          pause_d  = pause_inc;
          if (pause_x > limit_x) begin
            pause_d = '0;
            mon_d   = '0;
            if (last_dir_q) begin
              drive_d  = drive_q | PairFwd;
              mode_d   = MODE_FWD;
              status_d = ST_FWD_OK;
            end else begin
              drive_d  = drive_q | PairRev;
              mode_d   = MODE_REV;
              status_d = ST_REV_OK;
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= MODE_STOP;
      status_q   <= ST_NONE;
      last_dir_q <= 1'b0;
      mon_q      <= '0;
      pause_q    <= '0;
      last_fb_q  <= PairOff;
      drive_q    <= PairOff;
    end else if (accept_i) begin
      mode_q     <= mode_d;
      status_q   <= status_d;
      last_dir_q <= last_dir_d;
      mon_q      <= mon_d;
      pause_q    <= pause_d;
      last_fb_q  <= last_fb_d;
      drive_q    <= drive_d;
    end
  end

  assign res_o.drive  = drive_d;
  assign res_o.status = status_d;
  assign res_o.mode   = mode_d;

endmodule

FILE: src/rbc_merge.sv
// Merge stage: packs both lane results into one result and holds it in
// the output register until the transaction completes. Depends on rbc_pkg.
module rbc_merge import rbc_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      accept_i,
  input  lane_res_t res0_i,
  input  lane_res_t res1_i,
  output logic      can_accept_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_item_o
);

  logic      valid_q, valid_d;
  out_item_t item_q, item_d;

  assign can_accept_o = !valid_q || out_ready_i;

  always_comb begin
    valid_d = valid_q;
    if (out_ready_i) valid_d = 1'b0;
    if (accept_i) valid_d = 1'b1;

    item_d.drive      = {res1_i.drive, res0_i.drive};
    item_d.status_ch0 = res0_i.status;
    item_d.status_ch1 = res1_i.status;
    item_d.mode_ch0   = res0_i.mode;
    item_d.mode_ch1   = res1_i.mode;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      item_q <= item_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_item_o  = item_q;

endmodule

FILE: src/reversible_blower_controller.sv
// Reversible blower controller, top level. Uses rbc_pkg, rbc_lane, rbc_merge.
// Latency: the result of a transaction is registered at its accept edge and is
// offered on the output channel in the next cycle. Throughput: one item per cycle
// if out_ready_i allows, set by the single output register, refilled as drained.
// Reset (rst_ni, asynchronous, active low): all channels stopped, drives off,
// counters and status cleared, check_period = 100, pause_ticks = 500.
module reversible_blower_controller import rbc_pkg::*; #(
  parameter int unsigned COUNT_WIDTH = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,

  // Input item channel.
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  in_item_t    in_item_i,

  // Result channel.
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output out_item_t   out_item_o,

  // Configuration port.
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam logic [CfgWidth-1:0] CheckPeriodRst = CfgWidth'(100);
  localparam logic [CfgWidth-1:0] PauseTicksRst  = CfgWidth'(500);

  logic [CfgWidth-1:0] check_period_q, check_period_d;
  logic [CfgWidth-1:0] pause_ticks_q, pause_ticks_d;
  reg_idx_e            reg_idx;
  logic                cfg_write;

  // ---------------------------------------------------------------------------
  // Configuration registers. The port never stalls, so a write lands at the
  // access cycle of the transaction. Reads return the current register value.
  // The register index is taken from the word address of the APB port.
  // ---------------------------------------------------------------------------
  assign pready    = 1'b1;
  assign reg_idx   = reg_idx_e'(paddr[2]);
  assign cfg_write = psel && penable && pwrite && pready;

  always_comb begin
    check_period_d = check_period_q;
    pause_ticks_d  = pause_ticks_q;
    prdata         = '0;
    unique case (reg_idx)
      REG_CHECK_PERIOD: begin
        prdata = 32'(check_period_q);
        if (cfg_write) check_period_d = pwdata[CfgWidth-1:0];
      end
      REG_PAUSE_TICKS: begin
        prdata = 32'(pause_ticks_q);
        if (cfg_write) pause_ticks_d = pwdata[CfgWidth-1:0];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      check_period_q <= CheckPeriodRst;
      pause_ticks_q  <= PauseTicksRst;
    end else begin
      check_period_q <= check_period_d;
      pause_ticks_q  <= pause_ticks_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Input handshake. An item is taken whenever the output register is empty or
  // is being drained in the same cycle, so the block streams at full rate.
  // ---------------------------------------------------------------------------
  logic      in_fire;
  logic      can_accept;
  lane_res_t lane_res [NumCh];
  logic [1:0] lane_event [NumCh];

  assign in_ready_o = can_accept;
  assign in_fire    = in_valid_i && can_accept;

  assign lane_event[0] = in_item_i.event_ch0;
  assign lane_event[1] = in_item_i.event_ch1;

  // ---------------------------------------------------------------------------
  // Channel lanes. Each lane holds the full state of one blower and updates it
  // only when a transaction is accepted. The two lanes are independent; each
  // sees its own event and its own pair of feedback bits.
  // ---------------------------------------------------------------------------
  for (genvar ch = 0; ch < NumCh; ch++) begin : g_lane
    rbc_lane #(
      .COUNT_WIDTH (COUNT_WIDTH)
    ) u_lane (
      .clk_i          (clk_i),
      .rst_ni         (rst_ni),
      .accept_i       (in_fire),
      .command_i      (in_item_i.command),
      .event_i        (lane_event[ch]),
      .feedback_i     (in_item_i.feedback[2*ch +: 2]),
      .check_period_i (check_period_q),
      .pause_ticks_i  (pause_ticks_q),
      .res_o          (lane_res[ch])
    );
  end

  // ---------------------------------------------------------------------------
  // Merge stage and output register.
  // ---------------------------------------------------------------------------
  rbc_merge u_merge (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (in_fire),
    .res0_i       (lane_res[0]),
    .res1_i       (lane_res[1]),
    .can_accept_o (can_accept),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_item_o   (out_item_o)
  );

`ifndef NO_ASSERTIONS
  // A paused channel always has its drive pair switched off.
  a_pause_drive_off_ch0: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_item_o.mode_ch0 == MODE_PAUSE) |-> out_item_o.drive[1:0] == PairOff)
    else $error("channel 0 paused with drive on");

  a_pause_drive_off_ch1: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_item_o.mode_ch1 == MODE_PAUSE) |-> out_item_o.drive[3:2] == PairOff)
    else $error("channel 1 paused with drive on");

  // Every accepted transaction produces a result in the following cycle.
  a_accept_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> out_valid_o)
    else $error("accepted item did not produce a result");
`endif

endmodule
